### rtl/sidaf_pkg.sv
// Shared types and constants for the sorted ID acceptance filter.
`default_nettype none
package sidaf_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int PGN_W           = 24;
    localparam int ADDR_W          = 8;
    localparam int ENTRY_W         = PGN_W + ADDR_W;
    localparam int S_TDATA_W       = 32;
    localparam int M_TDATA_W       = 8;

    localparam logic [PGN_W-1:0]  PGN_LIMIT_RST = 24'h03FFFF;
    localparam logic [ADDR_W-1:0] ADDR_WILDCARD = 8'h00;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FILTER = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch incoming transaction
        logic add_init;   // idx <= count - 1
        logic idx_dec;    // idx <= idx - 1
        logic flt_init;   // lo <= 0, hi_x <= count
        logic lo_up;      // lo <= mid + 1
        logic hi_down;    // hi_x <= mid
        logic count_inc;
        logic wr_en;
        logic wr_zero;    // write at 0 instead of idx + 1
        logic wr_new;     // write the new entry instead of the read entry
        logic rd_prev;    // read idx - 1
        logic rd_mid;     // read mid
        logic res_set;
        logic res_one;
        logic res_match;  // result comes from the address compare
        logic load_out;
    } sidaf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_filter;
        logic add_ok;
        logic count_zero;
        logic full;
        logic idx_zero;
        logic rd_gt;      // stored group number above the item's
        logic rd_lt;      // stored group number below the item's
        logic search_empty;
        logic out_free;
    } sidaf_sts_t;

endpackage
`default_nettype wire

### rtl/sidaf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module sidaf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/sidaf_ctrl.sv
// Controller state machine: sequences add (insert/shift) and filter (binary search).
`default_nettype none
module sidaf_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire sidaf_pkg::sidaf_sts_t sts,
    output sidaf_pkg::sidaf_cmd_t     cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SETUP   = 7'b0000010,
        ST_ADD_RD  = 7'b0000100,
        ST_ADD_CMP = 7'b0001000,
        ST_ADD_PUT = 7'b0010000,
        ST_FLT_RD  = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    // FLT_CMP has no code in state_t: it is a sub-state of ST_FLT_RD, kept below
    typedef enum logic [1:0] {
        SUB_NONE = 2'b01,
        SUB_CMP  = 2'b10
    } sub_t;

    state_t state_reg, state_next;
    sub_t   flt_reg, flt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            flt_reg   <= SUB_NONE;
        end else begin
            state_reg <= state_next;
            flt_reg   <= flt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        flt_next   = flt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (sts.op_filter) begin
                    cmd.flt_init = 1'b1;
                    flt_next     = SUB_NONE;
                    state_next   = ST_FLT_RD;
                end else if (!sts.add_ok) begin
                    cmd.res_set = 1'b1;
                    state_next  = ST_DONE;
                end else if (sts.count_zero) begin
                    state_next = ST_ADD_PUT;
                end else begin
                    cmd.add_init = 1'b1;
                    state_next   = ST_ADD_RD;
                end
            end
            ST_ADD_RD: begin
                state_next = ST_ADD_CMP;
            end
            ST_ADD_CMP: begin
                cmd.wr_en = 1'b1;
                if (sts.rd_gt) begin
                    // move entry up one slot
                    if (sts.idx_zero) begin
                        state_next = ST_ADD_PUT;
                    end else begin
                        cmd.idx_dec = 1'b1;
                        cmd.rd_prev = 1'b1;
                    end
                end else begin
                    cmd.wr_new    = 1'b1;
                    cmd.count_inc = 1'b1;
                    cmd.res_set   = 1'b1;
                    cmd.res_one   = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_ADD_PUT: begin
                cmd.wr_en     = 1'b1;
                cmd.wr_zero   = 1'b1;
                cmd.wr_new    = 1'b1;
                cmd.count_inc = 1'b1;
                cmd.res_set   = 1'b1;
                cmd.res_one   = 1'b1;
                state_next    = ST_DONE;
            end
            ST_FLT_RD: begin
                case (flt_reg)
                    SUB_NONE: begin
                        if (sts.search_empty) begin
                            cmd.res_set = 1'b1;
                            state_next  = ST_DONE;
                        end else begin
                            cmd.rd_mid = 1'b1;
                            flt_next   = SUB_CMP;
                        end
                    end
                    SUB_CMP: begin
                        flt_next = SUB_NONE;
                        if (sts.rd_gt) begin
                            cmd.hi_down = 1'b1;
                        end else if (sts.rd_lt) begin
                            cmd.lo_up = 1'b1;
                        end else begin
                            cmd.res_set   = 1'b1;
                            cmd.res_match = 1'b1;
                            state_next    = ST_DONE;
                        end
                    end
                    default: begin
                        flt_next = SUB_NONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/sidaf_dpath.sv
// Datapath: item and search registers, entry count, limit register, table RAM, result register.
`default_nettype none
module sidaf_dpath #(
    parameter int TABLE_DEPTH = sidaf_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [sidaf_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                               s_tuser,
    input  wire logic                               cfg_wr_en,
    input  wire logic [sidaf_pkg::PGN_W-1:0]        cfg_wr_data,
    input  wire logic                               m_tready,
    output logic                                    m_tvalid,
    output logic      [sidaf_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire sidaf_pkg::sidaf_cmd_t              cmd,
    output sidaf_pkg::sidaf_sts_t                   sts
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = sidaf_pkg::PGN_W;
    localparam int DW = sidaf_pkg::ADDR_W;
    localparam int EW = sidaf_pkg::ENTRY_W;

    logic          item_op_reg;
    logic [DW-1:0] item_addr_reg;
    logic [PW-1:0] item_pgn_reg;
    logic [PW-1:0] limit_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] idx_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] hix_reg;   // exclusive upper bound
    logic          res_reg;
    logic          m_valid_reg;
    logic          m_acc_reg;

    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [EW-1:0] rdata;
    logic [PW-1:0] rd_pgn;
    logic [DW-1:0] rd_addr;
    logic          addr_match;

    // (lo + hi) >> 1 with hi = hi_x - 1
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hix_reg} - (CW+1)'(1);
    assign mid     = mid_sum[AW:1];

    assign rd_pgn     = rdata[EW-1:DW];
    assign rd_addr    = rdata[DW-1:0];
    assign addr_match = (rd_addr == sidaf_pkg::ADDR_WILDCARD) || (rd_addr == item_addr_reg);

    always_comb begin
        if (cmd.rd_mid) begin
            raddr = mid;
        end else if (cmd.rd_prev) begin
            raddr = idx_reg - AW'(1);
        end else begin
            raddr = idx_reg;
        end
    end

    assign waddr = cmd.wr_zero ? '0 : idx_reg + AW'(1);
    assign wdata = cmd.wr_new ? {item_pgn_reg, item_addr_reg} : rdata;

    sidaf_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_op_reg   <= s_tuser;
            item_addr_reg <= s_tdata[DW-1:0];
            item_pgn_reg  <= s_tdata[DW+PW-1:DW];
        end
        if (cmd.add_init) begin
            idx_reg <= AW'(count_reg - CW'(1));
        end else if (cmd.idx_dec) begin
            idx_reg <= idx_reg - AW'(1);
        end
        if (cmd.flt_init) begin
            lo_reg  <= '0;
            hix_reg <= count_reg;
        end else begin
            if (cmd.lo_up) begin
                lo_reg <= CW'(mid) + CW'(1);
            end
            if (cmd.hi_down) begin
                hix_reg <= CW'(mid);
            end
        end
        if (cmd.res_set) begin
            res_reg <= cmd.res_match ? addr_match : cmd.res_one;
        end
        if (cmd.load_out) begin
            m_acc_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= sidaf_pkg::PGN_LIMIT_RST;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.count_inc) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts              = '0;
        sts.op_filter    = (item_op_reg == sidaf_pkg::OP_FILTER);
        sts.full         = (count_reg == CW'(TABLE_DEPTH));
        sts.count_zero   = (count_reg == '0);
        sts.add_ok       = (item_pgn_reg <= limit_reg) && !sts.full;
        sts.idx_zero     = (idx_reg == '0);
        sts.rd_gt        = (rd_pgn > item_pgn_reg);
        sts.rd_lt        = (rd_pgn < item_pgn_reg);
        sts.search_empty = (lo_reg >= hix_reg);
        sts.out_free     = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(sidaf_pkg::M_TDATA_W-1){1'b0}}, m_acc_reg};

endmodule
`default_nettype wire

### rtl/sorted_id_acceptance_filter.sv
// Top level of the sorted ID acceptance filter: controller, datapath and checks.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tdata {pgn[23:0], src_addr[7:0]}, tuser op
//  m_       | out | m_tvalid/m_tready  | tdata {7'b0, accepted}
//  cfg_     | in  | cfg_wr_en          | cfg_wr_data = pgn_limit[23:0]
//
// One transaction is worked on at a time. A filter lookup is a binary search of at
// most seven probes with 64 entries; each probe is a read of the table RAM and a
// compare. An add reads down from the last entry and moves each larger entry up
// one slot to open the slot for the new one (an empty table is written at slot 0);
// a rejected add goes straight to the result.
// aresetn (synchronous) empties the table and sets pgn_limit to 0x3FFFF.
// The result register lets the next transaction be accepted while the previous
// result waits on m_tready; a busy result register stalls only the final load.
`default_nettype none
module sorted_id_acceptance_filter #(
    parameter int TABLE_DEPTH = sidaf_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // request transaction
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [sidaf_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] src_addr, [31:8] pgn
    input  wire logic                            s_tuser,   // [0] op: 0 add, 1 filter
    // result transaction
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [sidaf_pkg::M_TDATA_W-1:0] m_tdata,   // [0] accepted, [7:1] zero
    // limit register write
    input  wire logic                            cfg_wr_en,
    input  wire logic [sidaf_pkg::PGN_W-1:0]     cfg_wr_data
);

    sidaf_pkg::sidaf_cmd_t cmd;
    sidaf_pkg::sidaf_sts_t sts;

    // sequencing: add scan/shift and binary search steps
    sidaf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table RAM, count, search bounds, result register
    sidaf_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

    // only one transaction in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    // a full table never grows
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count_inc |-> !sts.full)
        else $error("entry count incremented on a full table");

    // a pending result is never overwritten
    a_no_result_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result register loaded while still holding a result");

    // a probe is read only inside a non-empty search range
    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_mid |-> !sts.search_empty)
        else $error("search probe issued on an empty range");

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the sorted ID acceptance filter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sidaf_pkg::*;

    localparam int TABLE_DEPTH     = TABLE_DEPTH_DEF;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 40;    // idle margin after the last result
    localparam int RX_HOLD_CYCLES  = 400;   // long result-side stall
    localparam int WATCHDOG_CYCLES = 3000;  // cycles with no transaction on either side

    // One add or lookup as sent, with the verdict the filter should give
    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [PGN_W-1:0]  pgn;
        logic              accepted;
    } verdict_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [PGN_W-1:0]     cfg_wr_data = '0;

    // Shadow copy of the filter: sorted table, fill level, limit register
    logic [PGN_W-1:0]     shadow_pgn  [TABLE_DEPTH];
    logic [ADDR_W-1:0]    shadow_addr [TABLE_DEPTH];
    int                   shadow_count = 0;
    logic [PGN_W-1:0]     shadow_limit = PGN_LIMIT_RST;

    verdict_t             verdicts_due[$];
    int                   fail_count = 0;

    // Traffic shaping for sender and receiver, and the group number pool
    bit                   idle_en = 1'b1;
    bit                   rx_hold_request = 1'b0;
    bit                   tx_offering = 1'b0;
    int                   tx_gap = 0;
    logic [PGN_W-1:0]     pgn_pool [16];

    sorted_id_acceptance_filter #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow filter
    // ------------------------------------------------------------------

    // Insert after any equal group numbers; reject over limit or when full.
    function automatic logic shadow_insert(logic [ADDR_W-1:0] addr, logic [PGN_W-1:0] pgn);
        int pos;
        if (pgn > shadow_limit || shadow_count >= TABLE_DEPTH)
            return 1'b0;
        pos = 0;
        while (pos < shadow_count && pgn >= shadow_pgn[pos])
            pos++;
        for (int k = shadow_count; k > pos; k--) begin
            shadow_pgn[k]  = shadow_pgn[k-1];
            shadow_addr[k] = shadow_addr[k-1];
        end
        shadow_pgn[pos]  = pgn;
        shadow_addr[pos] = addr;
        shadow_count++;
        return 1'b1;
    endfunction

    // Binary search, midpoint (lo + hi) >> 1; first hit decides.
    function automatic logic shadow_lookup(logic [ADDR_W-1:0] addr, logic [PGN_W-1:0] pgn);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shadow_count - 1;
        while (lo <= hi) begin
            mid = (lo + hi) >> 1;
            if (pgn > shadow_pgn[mid])
                lo = mid + 1;
            else if (pgn < shadow_pgn[mid])
                hi = mid - 1;
            else
                return (shadow_addr[mid] == ADDR_WILDCARD) || (shadow_addr[mid] == addr);
        end
        return 1'b0;
    endfunction

    function automatic logic predict_verdict(logic op, logic [ADDR_W-1:0] addr,
                                             logic [PGN_W-1:0] pgn);
        if (op == OP_ADD)
            return shadow_insert(addr, pgn);
        return shadow_lookup(addr, pgn);
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int idle_gap();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one transaction and record its verdict once accepted. tvalid stays
    // high into the next call when no gap follows, so it never toggles in one step.
    task automatic send_item(logic op, logic [ADDR_W-1:0] addr, logic [PGN_W-1:0] pgn);
        verdict_t v;
        repeat (tx_gap) @(posedge aclk);
        s_tvalid    <= 1'b1;
        s_tdata     <= {pgn, addr};
        s_tuser     <= op;
        tx_offering  = 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        v.op       = op;
        v.addr     = addr;
        v.pgn      = pgn;
        v.accepted = predict_verdict(op, addr, pgn);
        verdicts_due.push_back(v);
        tx_gap = idle_gap();
        if (tx_gap > 0) begin
            s_tvalid   <= 1'b0;
            tx_offering = 1'b0;
        end
    endtask

    // Stop offering and let every outstanding verdict come back.
    task automatic wait_idle();
        if (tx_offering) begin
            s_tvalid   <= 1'b0;
            tx_offering = 1'b0;
        end
        tx_gap = 0;
        while (verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_pgn_limit(logic [PGN_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        shadow_limit = value;
        cfg_wr_en   <= 1'b0;
    endtask

    // Random group number: pool values give hits and duplicates, the rest spans all bits.
    function automatic logic [PGN_W-1:0] pick_pgn();
        if ($urandom_range(0, 99) < 75)
            return pgn_pool[$urandom_range(0, 15)];
        return PGN_W'($urandom());
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        if ($urandom_range(0, 99) < 25)
            return ADDR_WILDCARD;
        return ADDR_W'($urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Random back-pressure, plus one long hold on request.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                stall = ($urandom_range(0, 99) < 20) ? idle_gap() : 0;
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    stall--;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Compare every result transaction with the oldest verdict due.
    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                $error("result transaction with no request outstanding: accepted=%0b",
                       m_tdata[0]);
                fail_count++;
            end else begin
                v = verdicts_due.pop_front();
                if (m_tdata[0] !== v.accepted) begin
                    $error("accepted mismatch (%s pgn=%06h addr=%02h): expected %0b, got %0b",
                           (v.op == OP_ADD) ? "add" : "filter", v.pgn, v.addr,
                           v.accepted, m_tdata[0]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any transaction means the block hung.
    always @(posedge aclk) begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_empty_table();
        send_item(OP_FILTER, 8'h00, 24'h00_0000);     // empty table: drop
        send_item(OP_FILTER, 8'hFF, 24'hFF_FFFF);
        send_item(OP_ADD,    8'h12, PGN_LIMIT_RST + PGN_W'(1)); // just over reset limit
    endtask

    task automatic test_insert_and_lookup();
        send_item(OP_ADD,    8'hFF,         24'h00_0000);
        send_item(OP_ADD,    ADDR_WILDCARD, PGN_LIMIT_RST);   // exactly at limit
        send_item(OP_ADD,    8'h11,         24'h00_0100);
        send_item(OP_ADD,    8'h22,         24'h00_0100);     // equal number goes after
        send_item(OP_FILTER, 8'hAB,         PGN_LIMIT_RST);   // wildcard entry passes
        send_item(OP_FILTER, 8'hFF,         24'h00_0000);
        send_item(OP_FILTER, 8'h00,         24'h00_0000);     // address differs: drop
        send_item(OP_FILTER, 8'h01,         24'h00_0005);     // miss
        send_item(OP_FILTER, 8'h80,         24'hFF_FFFF);     // miss above all
        send_item(OP_FILTER, 8'h11,         24'h00_0100);
        send_item(OP_FILTER, 8'h22,         24'h00_0100);
        send_item(OP_FILTER, 8'h33,         24'h00_0100);
    endtask

    task automatic test_limit_extremes();
        set_pgn_limit(24'hFF_FFFF);
        send_item(OP_ADD,    8'h80, 24'hFF_FFFF);
        send_item(OP_FILTER, 8'h80, 24'hFF_FFFF);
        set_pgn_limit(24'h00_0000);
        send_item(OP_ADD,    8'h7F, 24'h00_0001);    // over a zero limit
        send_item(OP_ADD,    8'h5A, 24'h00_0000);
        send_item(OP_FILTER, 8'h5A, 24'h00_0000);
    endtask

    // Mixed adds and lookups; lookups mostly aim at stored entries.
    task automatic test_random_traffic(logic [PGN_W-1:0] limit, int count, bit gaps);
        int               idx;
        logic             op;
        logic [ADDR_W-1:0] addr;
        logic [PGN_W-1:0] pgn;
        set_pgn_limit(limit);
        idle_en = gaps;
        for (int n = 0; n < count; n++) begin
            op   = ($urandom_range(0, 99) < ((shadow_count < TABLE_DEPTH) ? 45 : 25))
                   ? OP_ADD : OP_FILTER;
            addr = pick_addr();
            pgn  = pick_pgn();
            if (op == OP_FILTER && shadow_count > 0 && $urandom_range(0, 99) < 65) begin
                idx = $urandom_range(0, shadow_count - 1);
                pgn = shadow_pgn[idx];
                if ($urandom_range(0, 99) < 50)
                    addr = shadow_addr[idx];
            end
            send_item(op, addr, pgn);
        end
        idle_en = 1'b1;
    endtask

    // Fill every slot, then one more add is refused by a full table.
    task automatic test_fill_table();
        while (shadow_count < TABLE_DEPTH)
            send_item(OP_ADD, pick_addr(), pick_pgn() & shadow_limit);
        send_item(OP_ADD,    8'h44, 24'h00_0000);
        send_item(OP_FILTER, 8'h44, shadow_pgn[0]);
        send_item(OP_FILTER, 8'h44, shadow_pgn[TABLE_DEPTH-1]);
    endtask

    // Receiver stalls long while requests keep coming back to back.
    task automatic test_result_backpressure();
        wait_idle();
        idle_en = 1'b0;
        rx_hold_request = 1'b1;
        for (int n = 0; n < 30; n++)
            send_item(OP_FILTER, pick_addr(), shadow_pgn[$urandom_range(0, TABLE_DEPTH - 1)]);
        idle_en = 1'b1;
    endtask

    initial begin
        // Pool mixes edge values with random ones
        pgn_pool[0] = 24'h00_0000;
        pgn_pool[1] = 24'h00_0001;
        pgn_pool[2] = 24'hFF_FFFF;
        pgn_pool[3] = 24'hFF_FFFE;
        pgn_pool[4] = PGN_LIMIT_RST;
        pgn_pool[5] = PGN_LIMIT_RST + PGN_W'(1);
        pgn_pool[6] = 24'h80_0000;
        pgn_pool[7] = 24'h7F_FFFF;
        for (int i = 8; i < 16; i++)
            pgn_pool[i] = PGN_W'($urandom());

        aresetn <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_insert_and_lookup();
        test_limit_extremes();
        test_random_traffic(24'hFF_FFFF, 60, 1'b1);
        test_fill_table();
        test_random_traffic(PGN_W'($urandom()), 250, 1'b1);
        test_random_traffic(PGN_LIMIT_RST, 250, 1'b0);
        test_result_backpressure();
        test_random_traffic(24'h00_0000, 250, 1'b1);
        test_random_traffic(pgn_pool[$urandom_range(8, 15)], 300, 1'b1);
        test_random_traffic(24'hFF_FFFF, 340, 1'b1);

        // Drain and leave room for any stray result
        wait_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
